### src/usc_pkg.sv
// Shared types and constants for the seconds-to-calendar conversion unit.
`timescale 1ns / 1ps

package usc_pkg;

  localparam int unsigned SecsW   = 32;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned TodW    = 17;
  localparam int unsigned YearW   = 12;
  localparam int unsigned CntW    = 3;

  // days = (secs >> 7) / 675, by multiply with 2^35 / 675 rounded up
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [9:0]  DayOdd    = 10'd675;
  // hours = (tod >> 4) / 225, by multiply with 2^21 / 225 rounded up
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [7:0]  HourOdd   = 8'd225;
  // minutes = (secs in hour >> 2) / 15, by multiply with 2^14 / 15 rounded up
  localparam logic [10:0] MinRecip  = 11'd1093;
  localparam logic [3:0]  MinOdd    = 4'd15;

  localparam logic [CntW-1:0] SplitLastCnt = 3'd5;

  localparam logic [YearW-1:0] FirstYear     = 12'd1970;
  localparam logic [6:0]       FirstYearM100 = 7'd70;
  localparam logic [8:0]       FirstYearM400 = 9'd370;
  localparam logic [6:0]       LastM100      = 7'd99;
  localparam logic [8:0]       LastM400      = 9'd399;
  localparam logic [8:0]       YearLenLeap   = 9'd366;
  localparam logic [8:0]       YearLenNorm   = 9'd365;
  localparam logic [3:0]       LastMonthIdx  = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_YEAR,
    ST_MONTH
  } ctrl_state_e;

  typedef struct packed {
    logic     load_in;
    logic     split_en;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } usc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } usc_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### src/unix_seconds_to_calendar_date_unit.sv
// Top level of the Unix seconds to Gregorian date and time converter.
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into day, month, year, hour, minute and second. One transaction is handled
// at a time: the count is first split into days and time of day by constant
// reciprocal multiplication, then years are stepped off one per cycle (up to
// 136) and months one per cycle (up to 11). When the result is loaded into
// the output register the unit returns to idle and the next input
// transaction can be accepted. The result sits in an output register, so the
// next transaction is processed while it waits to be taken; a stalled output
// holds the unit in its last month step.
module unix_seconds_to_calendar_date_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [11:0] year_number_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o
);
  import usc_pkg::*;

  usc_cmd_t    cmd;
  usc_status_t status;

  usc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  usc_datapath u_datapath (
    .clk_i              (clk_i),
    .epoch_seconds_i    (epoch_seconds_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .day_of_month_o     (day_of_month_o),
    .month_number_o     (month_number_o),
    .year_number_o      (year_number_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("busy not raised after input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_number_o >= 4'd1) && (month_number_o <= 4'd12) &&
                    (day_of_month_o >= 5'd1))
    else $error("date out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_of_day_o < 5'd24) && (minute_of_hour_o < 6'd60) &&
                    (second_of_minute_o < 6'd60))
    else $error("time of day out of range");

endmodule

### src/usc_datapath.sv
// Datapath: reciprocal multiply split, year and month stepping, output registers.
`timescale 1ns / 1ps

module usc_datapath (
  input  logic                clk_i,
  input  logic [31:0]         epoch_seconds_i,
  input  usc_pkg::usc_cmd_t   cmd_i,
  output usc_pkg::usc_status_t status_o,
  output logic [4:0]          day_of_month_o,
  output logic [3:0]          month_number_o,
  output logic [11:0]         year_number_o,
  output logic [4:0]          hour_of_day_o,
  output logic [5:0]          minute_of_hour_o,
  output logic [5:0]          second_of_minute_o
);
  import usc_pkg::*;

  logic [SecsW-1:0]  num_q;
  logic [DaysW-1:0]  days_q;
  logic [TodW-1:0]   tod_q;
  logic [11:0]       msec_q;
  logic [YearW-1:0]  year_q;
  logic [6:0]        m100_q;
  logic [8:0]        m400_q;
  logic [3:0]        month_q;
  logic [4:0]        hour_q;
  logic [5:0]        min_q;
  logic [5:0]        sec_q;

  logic [50:0]       day_prod;
  logic [9:0]        day_back;
  logic [9:0]        day_rest;
  logic [25:0]       hour_prod;
  logic [7:0]        hour_back;
  logic [7:0]        hour_rest;
  logic [19:0]       min_prod;
  logic [3:0]        min_back;
  logic [3:0]        min_rest;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;

  assign day_prod  = 51'(num_q[SecsW-1:7]) * 51'(DayRecip);
  assign day_back  = days_q[9:0] * DayOdd;
  assign day_rest  = num_q[16:7] - day_back;
  assign hour_prod = 26'(tod_q[16:4]) * 26'(HourRecip);
  assign hour_back = {3'd0, hour_q} * HourOdd;
  assign hour_rest = tod_q[11:4] - hour_back;
  assign min_prod  = 20'(msec_q[11:2]) * 20'(MinRecip);
  assign min_back  = min_q[3:0] * MinOdd;
  assign min_rest  = msec_q[5:2] - min_back;

  assign leap = (m400_q == 9'd0) || ((year_q[1:0] == 2'd0) && (m100_q != 7'd0));
  assign ylen = leap ? YearLenLeap : YearLenNorm;
  assign mlen = month_len(month_q, leap);

  assign status_o.year_done  = (days_q < {7'd0, ylen});
  assign status_o.month_done = (month_q == LastMonthIdx) || (days_q < {11'd0, mlen});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      num_q   <= epoch_seconds_i;
      year_q  <= FirstYear;
      m100_q  <= FirstYearM100;
      m400_q  <= FirstYearM400;
      month_q <= '0;
    end else if (cmd_i.split_en) begin
      days_q <= day_prod[50:35];
      tod_q  <= {day_rest, num_q[6:0]};
      hour_q <= hour_prod[25:21];
      msec_q <= {hour_rest, tod_q[3:0]};
      min_q  <= min_prod[19:14];
      sec_q  <= {min_rest, msec_q[1:0]};
    end else if (cmd_i.year_step) begin
      days_q <= days_q - {7'd0, ylen};
      year_q <= year_q + 12'd1;
      m100_q <= (m100_q == LastM100) ? 7'd0 : m100_q + 7'd1;
      m400_q <= (m400_q == LastM400) ? 9'd0 : m400_q + 9'd1;
    end else if (cmd_i.month_step) begin
      days_q  <= days_q - {11'd0, mlen};
      month_q <= month_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      day_of_month_o     <= days_q[4:0] + 5'd1;
      month_number_o     <= month_q + 4'd1;
      year_number_o      <= year_q;
      hour_of_day_o      <= hour_q;
      minute_of_hour_o   <= min_q;
      second_of_minute_o <= sec_q;
    end
  end

endmodule

### src/usc_ctrl.sv
// Controller: sequences the split into days and time, year and month stepping, output handoff.
`timescale 1ns / 1ps

module usc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  usc_pkg::usc_status_t status_i,
  output usc_pkg::usc_cmd_t    cmd_o
);
  import usc_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              in_accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SPLIT;
          cnt_d   = SplitLastCnt;
        end
      end
      ST_SPLIT: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          state_d = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status_i.month_done && slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_accept;
      end
      ST_SPLIT: begin
        cmd_o.split_en = 1'b1;
      end
      ST_YEAR: begin
        cmd_o.year_step = !status_i.year_done;
      end
      ST_MONTH: begin
        cmd_o.month_step = !status_i.month_done;
        if (status_i.month_done && slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
